@@ hw/rtl/mnp_pkg.sv @@
`default_nettype none
package mnp_pkg;

   localparam int VALUE_BITS     = 64;
   localparam int HEX_DIGITS_MAX = 16;
   localparam int CHAR_BITS      = 8;
   localparam int COUNT_BITS     = 7;
   localparam int STATUS_BITS    = 3;
   localparam int BASE_BITS      = 2;

   // largest decimal accumulator that may still take a further digit
   localparam logic [VALUE_BITS-1:0] DEC_LIMIT = 64'd1844674407370955161;

   typedef enum logic [1:0] {
      RADIX_DEC = 2'd0,
      RADIX_HEX = 2'd1,
      RADIX_BIN = 2'd2
   } radix_type;

   typedef enum logic [STATUS_BITS-1:0] {
      ST_OK        = 3'd0,
      ST_EMPTY     = 3'd1,
      ST_NO_DIGITS = 3'd2,
      ST_BAD_DIGIT = 3'd3,
      ST_TOO_LARGE = 3'd4
   } status_type;

   // one accepted character beat
   typedef struct packed {
      logic [CHAR_BITS-1:0] char_code;
      logic                 last_char;
   } beat_type;

   // one result beat
   typedef struct packed {
      logic [VALUE_BITS-1:0] value;
      status_type            status;
      radix_type             base_seen;
   } result_type;

endpackage
`default_nettype wire

@@ hw/rtl/mnp_stream_if.sv @@
`default_nettype none
interface mnp_req_if;
   logic                          valid;
   logic                          ready;
   logic [mnp_pkg::CHAR_BITS-1:0] char_code;
   logic                          last_char;

   modport source (output valid, char_code, last_char, input ready);
   modport sink   (input valid, char_code, last_char, output ready);
endinterface

interface mnp_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [mnp_pkg::VALUE_BITS-1:0]  value;
   logic [mnp_pkg::STATUS_BITS-1:0] status;
   logic [mnp_pkg::BASE_BITS-1:0]   base_seen;

   modport source (output valid, value, status, base_seen, input ready);
   modport sink   (input valid, value, status, base_seen, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/mnp_in_reg.sv @@
`default_nettype none
module mnp_in_reg (
   input  wire logic               clock,
   input  wire logic               reset,
   mnp_req_if.sink                 req_chan,
   input  wire logic               advance,
   output logic                    beat_valid,
   output mnp_pkg::beat_type       beat
);
   import mnp_pkg::*;

   logic     valid_ff, valid_in;
   beat_type beat_ff, beat_in;
   logic     take;

   // accept a new beat whenever the slot is empty or drains this cycle
   assign req_chan.ready = !valid_ff || advance;
   assign take           = req_chan.valid && req_chan.ready;
   assign valid_in       = take || (valid_ff && !advance);

   always_comb begin
      beat_in = beat_ff;
      if (take) begin
         beat_in.char_code = req_chan.char_code;
         beat_in.last_char = req_chan.last_char;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      beat_ff <= beat_in;
   end

   assign beat_valid = valid_ff;
   assign beat       = beat_ff;
endmodule
`default_nettype wire

@@ hw/rtl/mnp_token_step.sv @@
`default_nettype none
module mnp_token_step (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               beat_valid,
   input  wire mnp_pkg::beat_type  beat,
   input  wire logic               out_free,
   output logic                    advance,
   output logic                    load_rsp,
   output mnp_pkg::result_type     result
);
   import mnp_pkg::*;

   typedef enum logic [2:0] {
      PH_FIRST = 3'd0,
      PH_ZERO  = 3'd1,
      PH_LEAD  = 3'd2,
      PH_BODY  = 3'd3,
      PH_DONE  = 3'd4,
      PH_EMPTY = 3'd5
   } phase_type;

   typedef struct packed {
      phase_type             phase;
      radix_type             radix;
      logic [VALUE_BITS-1:0] acc;
      logic [COUNT_BITS-1:0] count;
      logic                  bad;
      logic                  big;
      logic                  order;
      logic                  trail;
   } tok_state_type;

   localparam tok_state_type STATE_RESET = '{
      phase: PH_FIRST, radix: RADIX_DEC, acc: '0, count: '0,
      bad: 1'b0, big: 1'b0, order: 1'b0, trail: 1'b0};

   function automatic logic is_space(input logic [CHAR_BITS-1:0] c);
      return (c == 8'd32) || ((c >= 8'd9) && (c <= 8'd13));
   endfunction

   function automatic tok_state_type note_bad(input tok_state_type s);
      tok_state_type r;
      r = s;
      if (!s.bad) begin
         r.bad = 1'b1;
         if (!s.big) r.order = 1'b0;
      end
      return r;
   endfunction

   function automatic tok_state_type note_large(input tok_state_type s);
      tok_state_type r;
      r = s;
      if (!s.big) begin
         r.big = 1'b1;
         if (!s.bad) r.order = 1'b1;
      end
      return r;
   endfunction

   // one character of the number body
   function automatic tok_state_type body_char(input tok_state_type s,
                                               input logic [CHAR_BITS-1:0] c);
      tok_state_type           r;
      logic [CHAR_BITS-1:0]    dnum;
      logic [CHAR_BITS-1:0]    dup;
      logic [CHAR_BITS-1:0]    dlow;
      logic [3:0]              nib;
      logic                    hex_ok;
      logic [COUNT_BITS-1:0]   cnt;
      logic [VALUE_BITS-1:0]   dec_next;
      r        = s;
      dnum     = c - 8'd48;
      dup      = c - 8'd55;
      dlow     = c - 8'd87;
      nib      = 4'd0;
      hex_ok   = 1'b1;
      cnt      = (s.count == '1) ? s.count : s.count + 1'b1;
      dec_next = {s.acc[VALUE_BITS-4:0], 3'b000} + {s.acc[VALUE_BITS-2:0], 1'b0}
               + {{(VALUE_BITS-4){1'b0}}, dnum[3:0]};
      if ((c >= 8'd48) && (c <= 8'd57)) nib = dnum[3:0];
      else if ((c >= 8'd65) && (c <= 8'd70)) nib = dup[3:0];
      else if ((c >= 8'd97) && (c <= 8'd102)) nib = dlow[3:0];
      else hex_ok = 1'b0;

      if (c == 8'd0) begin
         r.phase = PH_DONE;
      end else if (is_space(c)) begin
         r.trail = 1'b1;
      end else if (s.trail) begin
         r = note_bad(s);
      end else if (c == 8'd95) begin
         r = s;
      end else begin
         case (s.radix)
            RADIX_HEX: begin
               if (!hex_ok) begin
                  r = note_bad(s);
               end else begin
                  r.count = cnt;
                  if (cnt > COUNT_BITS'(HEX_DIGITS_MAX)) r = note_large(r);
                  r.acc = {s.acc[VALUE_BITS-5:0], nib};
               end
            end
            RADIX_BIN: begin
               if ((c != 8'd48) && (c != 8'd49)) begin
                  r = note_bad(s);
               end else begin
                  r.count = cnt;
                  if (cnt > COUNT_BITS'(VALUE_BITS)) r = note_large(r);
                  r.acc = {s.acc[VALUE_BITS-2:0], c[0]};
               end
            end
            default: begin
               if ((c < 8'd48) || (c > 8'd57)) begin
                  r = note_bad(s);
               end else begin
                  r.count = cnt;
                  if (!s.big) begin
                     if ((s.acc > DEC_LIMIT) ||
                         ((s.acc == DEC_LIMIT) && (dnum > 8'd5))) begin
                        r = note_large(r);
                     end else begin
                        r.acc = dec_next;
                     end
                  end
               end
            end
         endcase
      end
      return r;
   endfunction

   // prefix handling, then the body
   function automatic tok_state_type take_char(input tok_state_type s,
                                               input logic [CHAR_BITS-1:0] c);
      tok_state_type r;
      tok_state_type z;
      r = s;
      z = s;
      case (s.phase)
         PH_FIRST: begin
            if (c == 8'd0) r.phase = PH_EMPTY;
            else if (c == 8'd48) r.phase = PH_ZERO;
            else if (is_space(c)) r.phase = PH_LEAD;
            else begin
               z.phase = PH_BODY;
               r = body_char(z, c);
            end
         end
         PH_ZERO: begin
            if ((c == 8'd120) || (c == 8'd88)) begin
               r.radix = RADIX_HEX;
               r.phase = PH_BODY;
            end else if ((c == 8'd98) || (c == 8'd66)) begin
               r.radix = RADIX_BIN;
               r.phase = PH_BODY;
            end else if ((c == 8'd100) || (c == 8'd68)) begin
               r.phase = PH_LEAD;
            end else begin
               // leading zero counts as one decimal digit of value zero
               z.phase = PH_BODY;
               z.count = {{(COUNT_BITS-1){1'b0}}, 1'b1};
               r = body_char(z, c);
            end
         end
         PH_LEAD: begin
            if (c == 8'd0) r.phase = PH_DONE;
            else if (!is_space(c)) begin
               z.phase = PH_BODY;
               r = body_char(z, c);
            end
         end
         PH_BODY: r = body_char(s, c);
         default: r = s;
      endcase
      return r;
   endfunction

   tok_state_type state_ff, state_in;
   tok_state_type next_state;
   status_type    status;
   logic          lone_zero;

   // advance the beat unless a result is due and the output slot is held
   assign advance  = beat_valid && (!beat.last_char || out_free);
   assign load_rsp = advance && beat.last_char;

   assign next_state = take_char(state_ff, beat.char_code);
   assign lone_zero  = (next_state.phase == PH_ZERO);

   // classify the finished token
   always_comb begin
      if (next_state.phase == PH_EMPTY) status = ST_EMPTY;
      else if (next_state.bad && next_state.big) begin
         if ((next_state.radix == RADIX_BIN) && next_state.order) status = ST_TOO_LARGE;
         else status = ST_BAD_DIGIT;
      end else if (next_state.bad) status = ST_BAD_DIGIT;
      else if (next_state.big) status = ST_TOO_LARGE;
      else if ((next_state.count == '0) && !lone_zero) status = ST_NO_DIGITS;
      else status = ST_OK;
   end

   assign result.value     = (status == ST_OK) ? next_state.acc : '0;
   assign result.status    = status;
   assign result.base_seen = next_state.radix;

   // drop back to reset after the last beat of a token
   always_comb begin
      state_in = state_ff;
      if (advance) state_in = beat.last_char ? STATE_RESET : next_state;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= STATE_RESET;
      end else begin
         state_ff <= state_in;
      end
   end
endmodule
`default_nettype wire

@@ hw/rtl/mnp_out_reg.sv @@
`default_nettype none
module mnp_out_reg (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 load_rsp,
   input  wire mnp_pkg::result_type  result,
   output logic                      out_free,
   mnp_rsp_if.source                 rsp_chan
);
   import mnp_pkg::*;

   logic       valid_ff, valid_in;
   result_type result_ff, result_in;

   // slot is free when empty or being taken this cycle
   assign out_free = !valid_ff || rsp_chan.ready;
   assign valid_in = load_rsp || (valid_ff && !rsp_chan.ready);

   always_comb begin
      result_in = result_ff;
      if (load_rsp) result_in = result;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      result_ff <= result_in;
   end

   assign rsp_chan.valid     = valid_ff;
   assign rsp_chan.value     = result_ff.value;
   assign rsp_chan.status    = result_ff.status;
   assign rsp_chan.base_seen = result_ff.base_seen;
endmodule
`default_nettype wire

@@ hw/rtl/multibase_number_token_parser_core.sv @@
// Channel    Dir  Payload                              Beat
// req_chan   in   char_code[7:0], last_char            one token character
// rsp_chan   out  value[63:0], status[2:0], base_seen  one result per token
//
// One character per cycle unless a held result stalls a last character; a result is
// loaded into the result register from its last character in the input register.
// The per-character update (times-ten add with limit compare, or shift-in) sits
// between the input register and the token state registers.
// Synchronous active-high reset returns the token state to the start of a token.
// A held result stalls input only when a further last character needs the slot.
`default_nettype none
module multibase_number_token_parser_core (
   input  wire logic clock,
   input  wire logic reset,
   mnp_req_if.sink   req_chan,
   mnp_rsp_if.source rsp_chan
);
   import mnp_pkg::*;

   logic       beat_valid;
   beat_type   beat;
   logic       advance;
   logic       load_rsp;
   logic       out_free;
   result_type result;

   mnp_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .advance    (advance),
      .beat_valid (beat_valid),
      .beat       (beat)
   );

   mnp_token_step u_token_step (
      .clock      (clock),
      .reset      (reset),
      .beat_valid (beat_valid),
      .beat       (beat),
      .out_free   (out_free),
      .advance    (advance),
      .load_rsp   (load_rsp),
      .result     (result)
   );

   mnp_out_reg u_out_reg (
      .clock    (clock),
      .reset    (reset),
      .load_rsp (load_rsp),
      .result   (result),
      .out_free (out_free),
      .rsp_chan (rsp_chan)
   );
endmodule
`default_nettype wire
